// ===== hw/rtl/interval_max_clique_sweep_core_assert.svh =====
// Assertion helpers used by imcs_back; they expect clk and rst_n in scope.
`ifndef INTERVAL_MAX_CLIQUE_SWEEP_CORE_ASSERT_SVH
`define INTERVAL_MAX_CLIQUE_SWEEP_CORE_ASSERT_SVH

// Same-cycle implication.
`define IMCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IMCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/imcs_pkg.sv =====
package imcs_pkg;

  // Operation kind carried in the input tuser bit.
  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_FINISH = 1'b1
  } imcs_op_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PASS   = 4'b0010,
    ST_APPEND = 4'b0100,
    ST_EMPTY  = 4'b1000
  } imcs_state_t;

endpackage

// ===== hw/rtl/interval_max_clique_sweep_core.sv =====
// Interval clique sweep. Send intervals (item id, entry, exit) in nondecreasing
// entry order with in_tuser low, and a finish item with in_tuser high to close
// the run. The core keeps up to MAX_OPEN open intervals in arrival order in one
// single-port-write, registered-read RAM. When an arrival sees an open interval
// whose exit is at or before its entry, and the newest open interval has not
// yet been reported, the whole open set is sent out as one clique, one member
// per output item, in arrival order, tlast on the final member; the expired
// intervals are then dropped and the new one appended. Finish sends the open
// set as the final clique (a single item with tlast and the empty flag when
// nothing is open) and clears everything, including the overflow flag.
// An arrival that finds the set full after expiry is dropped and sets the
// sticky overflow flag, which every output item carries as it stood before.
// Sequence: an arrival that expires nothing is appended as it is accepted. One
// that expires something walks the open set through the RAM read port, one
// entry a cycle while the output takes its items, emitting and compacting in
// the same pass, and then appends the new interval in a separate step. Finish
// walks the open set the same way, or sends the empty item when nothing is
// open. Output back-pressure stalls the walk while it emits.
// A two-item queue sits in front, so up to two items are taken while a walk runs.
// No clearing pass after reset is needed: only entries below the count are
// ever read.
module interval_max_clique_sweep_core
  import imcs_pkg::*;
#(
  parameter int MAX_OPEN   = 32,
  parameter int ID_WIDTH   = 10,
  parameter int TIME_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  // item in
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // tdata, low bit up: item_id, entry_time, exit_time, zero padding
  input  logic [((ID_WIDTH+2*TIME_WIDTH+7)/8)*8-1:0]     in_tdata,
  // tuser: command (0 arrival, 1 finish)
  input  logic                                           in_tuser,
  // clique members out
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // tdata, low bit up: member_id, zero padding
  output logic [((ID_WIDTH+7)/8)*8-1:0]                  out_tdata,
  // tlast: last_member
  output logic                                           out_tlast,
  // tuser, low bit up: empty_clique, overflow
  output logic [1:0]                                     out_tuser
);

  localparam int IN_DW  = ((ID_WIDTH + 2 * TIME_WIDTH + 7) / 8) * 8;
  localparam int OUT_DW = ((ID_WIDTH + 7) / 8) * 8;

  logic                  q_valid;
  logic                  q_ready;
  imcs_op_t              q_kind;
  logic [ID_WIDTH-1:0]   q_id;
  logic [TIME_WIDTH-1:0] q_entry;
  logic [TIME_WIDTH-1:0] q_exit;
  logic [ID_WIDTH-1:0]   out_id;
  logic                  out_empty;
  logic                  out_ovf;

  // front: takes items, decodes the command, queues them
  imcs_front #(
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH),
    .DATA_WIDTH (IN_DW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_kind    (q_kind),
    .q_id      (q_id),
    .q_entry   (q_entry),
    .q_exit    (q_exit)
  );

  // back: open-set RAM, emit/compact walk, output register
  imcs_back #(
    .MAX_OPEN   (MAX_OPEN),
    .ID_WIDTH   (ID_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_kind    (q_kind),
    .q_id      (q_id),
    .q_entry   (q_entry),
    .q_exit    (q_exit),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_id    (out_id),
    .out_last  (out_tlast),
    .out_empty (out_empty),
    .out_ovf   (out_ovf)
  );

  assign out_tdata = OUT_DW'(out_id);
  assign out_tuser = {out_ovf, out_empty};

endmodule

// ===== hw/rtl/imcs_ram.sv =====
module imcs_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/imcs_front.sv =====
module imcs_front
  import imcs_pkg::*;
#(
  parameter int ID_WIDTH   = 10,
  parameter int TIME_WIDTH = 16,
  parameter int DATA_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output imcs_op_t              q_kind,
  output logic [ID_WIDTH-1:0]   q_id,
  output logic [TIME_WIDTH-1:0] q_entry,
  output logic [TIME_WIDTH-1:0] q_exit
);

  // two-entry queue between the input port and the sequencer
  localparam int QD = 2;

  imcs_op_t              kind_r  [QD];
  logic [ID_WIDTH-1:0]   id_r    [QD];
  logic [TIME_WIDTH-1:0] entry_r [QD];
  logic [TIME_WIDTH-1:0] exit_r  [QD];

  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  imcs_op_t   kind_in;

  assign kind_in   = (in_tuser == 1'b1) ? OP_FINISH : OP_ARRIVE;
  assign in_tready = (fill_r != 2'(QD));
  assign q_valid   = (fill_r != 2'd0);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  assign q_kind  = kind_r[rp_r];
  assign q_id    = id_r[rp_r];
  assign q_entry = entry_r[rp_r];
  assign q_exit  = exit_r[rp_r];

  always_comb begin
    wp_nxt   = push ? ~wp_r : wp_r;
    rp_nxt   = pop ? ~rp_r : rp_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_r[wp_r]  <= kind_in;
      id_r[wp_r]    <= in_tdata[ID_WIDTH-1:0];
      entry_r[wp_r] <= in_tdata[ID_WIDTH+TIME_WIDTH-1:ID_WIDTH];
      exit_r[wp_r]  <= in_tdata[ID_WIDTH+2*TIME_WIDTH-1:ID_WIDTH+TIME_WIDTH];
    end
  end

endmodule

// ===== hw/rtl/imcs_back.sv =====
`include "interval_max_clique_sweep_core_assert.svh"

module imcs_back
  import imcs_pkg::*;
#(
  parameter int MAX_OPEN   = 32,
  parameter int ID_WIDTH   = 10,
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  imcs_op_t              q_kind,
  input  logic [ID_WIDTH-1:0]   q_id,
  input  logic [TIME_WIDTH-1:0] q_entry,
  input  logic [TIME_WIDTH-1:0] q_exit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_WIDTH-1:0]   out_id,
  output logic                  out_last,
  output logic                  out_empty,
  output logic                  out_ovf
);

  localparam int AW = $clog2(MAX_OPEN);
  localparam int CW = $clog2(MAX_OPEN + 1);
  localparam int MW = ID_WIDTH + TIME_WIDTH;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OPEN);

  imcs_state_t state_r, state_nxt;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] min_r, min_nxt;
  logic                  newest_r, newest_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [ID_WIDTH-1:0]   id_r, id_nxt;
  logic [TIME_WIDTH-1:0] entry_r, entry_nxt;
  logic [TIME_WIDTH-1:0] exit_r, exit_nxt;
  logic                  emit_r, emit_nxt;
  logic                  compact_r, compact_nxt;
  logic                  fin_r, fin_nxt;

  logic [CW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic                  d_vld_r, d_vld_nxt;
  logic [CW-1:0]         d_idx_r, d_idx_nxt;
  logic [CW-1:0]         w_r, w_nxt;
  logic [TIME_WIDTH-1:0] smin_r, smin_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ID_WIDTH-1:0]   out_id_r, out_id_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data, rd_data;

  logic                  slot_free;
  logic                  expired_q;
  logic                  pass_done;
  logic [ID_WIDTH-1:0]   rd_id;
  logic [TIME_WIDTH-1:0] rd_exit;

  imcs_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_OPEN)
  ) u_open_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_id     = rd_data[ID_WIDTH-1:0];
  assign rd_exit   = rd_data[MW-1:ID_WIDTH];
  assign slot_free = !out_valid_r || out_ready;
  // min_r is the smallest exit of the open set, so one compare tells expiry
  assign expired_q = (cnt_r != '0) && (min_r <= q_entry);
  assign pass_done = !d_vld_r && (rd_ptr_r == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    newest_nxt    = newest_r;
    ovf_nxt       = ovf_r;
    id_nxt        = id_r;
    entry_nxt     = entry_r;
    exit_nxt      = exit_r;
    emit_nxt      = emit_r;
    compact_nxt   = compact_r;
    fin_nxt       = fin_r;
    rd_ptr_nxt    = rd_ptr_r;
    d_vld_nxt     = d_vld_r;
    d_idx_nxt     = d_idx_r;
    w_nxt         = w_r;
    smin_nxt      = smin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    q_ready       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = {q_exit, q_id};
    rd_en         = 1'b0;
    rd_addr       = rd_ptr_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          id_nxt     = q_id;
          entry_nxt  = q_entry;
          exit_nxt   = q_exit;
          rd_ptr_nxt = '0;
          d_vld_nxt  = 1'b0;
          w_nxt      = '0;
          if (q_kind == OP_FINISH) begin
            fin_nxt     = 1'b1;
            emit_nxt    = 1'b1;
            compact_nxt = 1'b0;
            state_nxt   = (cnt_r == '0) ? ST_EMPTY : ST_PASS;
          end else if (expired_q) begin
            fin_nxt     = 1'b0;
            emit_nxt    = !newest_r;
            compact_nxt = 1'b1;
            state_nxt   = ST_PASS;
          end else if (cnt_r == MAX_CNT) begin
            ovf_nxt = 1'b1;
          end else begin
            // nothing expires: append straight away
            wr_en      = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            min_nxt    = (cnt_r == '0 || q_exit < min_r) ? q_exit : min_r;
            newest_nxt = 1'b0;
          end
        end
      end

      ST_PASS: begin
        if (pass_done) begin
          if (fin_r) begin
            cnt_nxt    = '0;
            newest_nxt = 1'b0;
            ovf_nxt    = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            cnt_nxt   = w_r;
            min_nxt   = smin_r;
            state_nxt = ST_APPEND;
            if (emit_r) begin
              newest_nxt = 1'b1;
            end
          end
        end else if (!(d_vld_r && emit_r && !slot_free)) begin
          if (d_vld_r) begin
            if (emit_r) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = rd_id;
              out_last_nxt  = (d_idx_r + 1'b1 == cnt_r);
              out_empty_nxt = 1'b0;
              out_ovf_nxt   = ovf_r;
            end
            // survivors move down; the write slot never passes the read slot
            if (compact_r && rd_exit > entry_r) begin
              wr_en    = 1'b1;
              wr_addr  = w_r[AW-1:0];
              wr_data  = rd_data;
              w_nxt    = w_r + 1'b1;
              smin_nxt = (w_r == '0 || rd_exit < smin_r) ? rd_exit : smin_r;
            end
          end
          if (rd_ptr_r != cnt_r) begin
            rd_en      = 1'b1;
            d_vld_nxt  = 1'b1;
            d_idx_nxt  = rd_ptr_r;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end else begin
            d_vld_nxt = 1'b0;
          end
        end
      end

      ST_APPEND: begin
        state_nxt = ST_IDLE;
        if (cnt_r == MAX_CNT) begin
          ovf_nxt = 1'b1;
        end else begin
          wr_en      = 1'b1;
          wr_data    = {exit_r, id_r};
          cnt_nxt    = cnt_r + 1'b1;
          min_nxt    = (cnt_r == '0 || exit_r < min_r) ? exit_r : min_r;
          newest_nxt = 1'b0;
        end
      end

      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          newest_nxt    = 1'b0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      newest_r    <= 1'b0;
      ovf_r       <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      newest_r    <= newest_nxt;
      ovf_r       <= ovf_nxt;
      d_vld_r     <= d_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r       <= min_nxt;
    id_r        <= id_nxt;
    entry_r     <= entry_nxt;
    exit_r      <= exit_nxt;
    emit_r      <= emit_nxt;
    compact_r   <= compact_nxt;
    fin_r       <= fin_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    d_idx_r     <= d_idx_nxt;
    w_r         <= w_nxt;
    smin_r      <= smin_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;
  assign out_ovf   = out_ovf_r;

  `IMCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "open count above capacity")
  `IMCS_ASSERT_IMP(a_compact_order, (state_r == ST_PASS) && wr_en, (w_r <= d_idx_r) && compact_r, "compaction write ahead of read")
  `IMCS_ASSERT_NXT(a_finish_clears, (state_r == ST_PASS) && pass_done && fin_r, (cnt_r == '0) && !ovf_r && !newest_r, "finish left open state")
  `IMCS_ASSERT_IMP(a_empty_only_when_none, (state_r == ST_EMPTY), cnt_r == '0, "empty marker with open intervals")

endmodule
